@@ rtl/cqs_pkg.sv @@
// Shared constants, codes and helpers for the circular queue with search.
package cqs_pkg;

	localparam int DEPTH     = 16;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int CAP_W     = 5;
	localparam int OCC_W     = 5;
	localparam int PADDR_W   = 2;
	localparam int PDATA_W   = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// Advance a ring position, wrapping at the live capacity.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] pos,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		begin
			n = CNT_W'(pos) + CNT_W'(1);
			next_slot = (n >= cap) ? '0 : n[PTR_W-1:0];
		end
	endfunction

endpackage

@@ rtl/circular_queue_with_search_unit.sv @@
// Top level: ring-buffer queue of signed words with insert, remove and search.
//
// Usage:
//   Input channel (in_valid/in_ready, command, value) carries one beat per
//   operation: insert, remove, search, or a no-op code. Every input beat yields
//   exactly one result beat on the output channel (out_valid/out_ready, status,
//   data_out, occupancy), in order.
//   The APB port holds one register, capacity (5 bits, reset 16). Writing it
//   empties the queue; zero acts as one slot, values above the built depth act
//   as the full depth. Write it only while the block is idle.
// Timing:
//   Insert, overflow, underflow, empty search and no-op finish in the accept
//   cycle (result registered at that edge), one item per cycle unless stalled.
//   Remove does a synchronous RAM read of the head slot, then delivers it.
//   Search walks the held words oldest first, one RAM read per cycle, until
//   every held word was compared; a hit stops the walk early.
// Reset (arst_n low) empties the queue and sets capacity to 16; slot contents
//   are not cleared, and only held slots are ever read.
// Stall: the output register keeps its beat while out_ready is low; a further
//   finished result parks in a hold register and in_ready drops until it moves.
module circular_queue_with_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cqs_pkg::PADDR_W-1:0]    paddr,
	input  logic [cqs_pkg::PDATA_W-1:0]    pwdata,
	output logic [cqs_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cqs_pkg::CMD_W-1:0]      command,
	input  logic signed [cqs_pkg::DATA_W-1:0] value,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cqs_pkg::STATUS_W-1:0]   status,
	output logic signed [cqs_pkg::DATA_W-1:0] data_out,
	output logic [cqs_pkg::OCC_W-1:0]      occupancy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE_RD,
		S_SEARCH,
		S_HOLD
	} state_t;

	state_t state_q, state_nxt, state_d;

	logic [cqs_pkg::CAP_W-1:0]  cap_q;
	logic [cqs_pkg::CNT_W-1:0]  cap_live;
	logic [cqs_pkg::PTR_W-1:0]  head_q, head_nxt, tail_q, tail_nxt, pos_q, pos_nxt;
	logic [cqs_pkg::CNT_W-1:0]  count_q, count_nxt, issued_q, issued_nxt;
	logic [cqs_pkg::DATA_W-1:0] val_q;

	logic                       in_fire, cfg_wr, out_free;
	cqs_pkg::cmd_t              cmd;

	logic                       wr_en, rd_en;
	logic [cqs_pkg::PTR_W-1:0]  rd_addr;
	logic [cqs_pkg::DATA_W-1:0] rd_data;

	logic                       fin_valid;
	cqs_pkg::status_t           fin_status;
	logic [cqs_pkg::DATA_W-1:0] fin_data;
	logic [cqs_pkg::OCC_W-1:0]  fin_occ;

	cqs_pkg::status_t           hold_status_q, out_status_q;
	logic [cqs_pkg::DATA_W-1:0] hold_data_q, out_data_q;
	logic [cqs_pkg::OCC_W-1:0]  hold_occ_q, out_occ_q;
	logic                       out_valid_q;

	// --- configuration port ------------------------------------------------
	// Single register, so every write lands in capacity.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = cqs_pkg::PDATA_W'(cap_q);

	// Clamp capacity into the built ring.
	always_comb begin
		if (cap_q == '0) begin
			cap_live = cqs_pkg::CNT_W'(1);
		end else if (cqs_pkg::CNT_W'(cap_q) > cqs_pkg::CNT_W'(cqs_pkg::DEPTH)) begin
			cap_live = cqs_pkg::CNT_W'(cqs_pkg::DEPTH);
		end else begin
			cap_live = cqs_pkg::CNT_W'(cap_q);
		end
	end

	// --- handshakes --------------------------------------------------------
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cmd      = cqs_pkg::cmd_t'(command);

	// --- operation decode and search walk ----------------------------------
	always_comb begin
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		count_nxt  = count_q;
		pos_nxt    = pos_q;
		issued_nxt = issued_q;
		state_nxt  = state_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		fin_valid  = 1'b0;
		fin_status = cqs_pkg::ST_OK;
		fin_data   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (cmd)
						cqs_pkg::CMD_INSERT: begin
							fin_valid = 1'b1;
							if (count_q >= cap_live) begin
								fin_status = cqs_pkg::ST_OVERFLOW;
							end else begin
								wr_en     = 1'b1;
								tail_nxt  = cqs_pkg::next_slot(tail_q, cap_live);
								count_nxt = count_q + cqs_pkg::CNT_W'(1);
							end
						end
						cqs_pkg::CMD_REMOVE: begin
							if (count_q == '0) begin
								fin_valid  = 1'b1;
								fin_status = cqs_pkg::ST_UNDERFLOW;
							end else begin
								// Read the head word now, deliver it next cycle.
								rd_en     = 1'b1;
								count_nxt = count_q - cqs_pkg::CNT_W'(1);
								if (count_q == cqs_pkg::CNT_W'(1)) begin
									head_nxt = '0;
									tail_nxt = '0;
								end else begin
									head_nxt = cqs_pkg::next_slot(head_q, cap_live);
								end
								state_nxt = S_REMOVE_RD;
							end
						end
						cqs_pkg::CMD_SEARCH: begin
							if (count_q == '0) begin
								fin_valid  = 1'b1;
								fin_status = cqs_pkg::ST_NOT_FOUND;
							end else begin
								rd_en      = 1'b1;
								pos_nxt    = cqs_pkg::next_slot(head_q, cap_live);
								issued_nxt = cqs_pkg::CNT_W'(1);
								state_nxt  = S_SEARCH;
							end
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_REMOVE_RD: begin
				fin_valid = 1'b1;
				fin_data  = rd_data;
				state_nxt = S_IDLE;
			end
			S_SEARCH: begin
				// rd_data holds the word of the previous read; compare, then
				// issue the next read unless it matched or every held word was seen.
				if (rd_data == val_q) begin
					fin_valid  = 1'b1;
					fin_status = cqs_pkg::ST_FOUND;
					state_nxt  = S_IDLE;
				end else if (issued_q == count_q) begin
					fin_valid  = 1'b1;
					fin_status = cqs_pkg::ST_NOT_FOUND;
					state_nxt  = S_IDLE;
				end else begin
					rd_en      = 1'b1;
					rd_addr    = pos_q;
					pos_nxt    = cqs_pkg::next_slot(pos_q, cap_live);
					issued_nxt = issued_q + cqs_pkg::CNT_W'(1);
				end
			end
			S_HOLD: begin
				state_nxt = S_HOLD;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
		fin_occ = cqs_pkg::OCC_W'(count_nxt);
	end

	// Park a finished result when the output register is still occupied.
	always_comb begin
		if (fin_valid) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end else if (state_q == S_HOLD) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end else begin
			state_d = state_nxt;
		end
	end

	// --- queue pointers and capacity ---------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= cqs_pkg::CAP_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			issued_q <= '0;
		end else begin
			pos_q    <= pos_nxt;
			issued_q <= issued_nxt;
			if (cfg_wr) begin
				// Any capacity write drops the held words.
				cap_q   <= pwdata[cqs_pkg::CAP_W-1:0];
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else begin
				head_q  <= head_nxt;
				tail_q  <= tail_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// Search key, captured with the beat.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_q <= value;
		end
	end

	// --- state, hold register and output register --------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			out_status_q  <= cqs_pkg::ST_OK;
			out_data_q    <= '0;
			out_occ_q     <= '0;
			hold_status_q <= cqs_pkg::ST_OK;
			hold_data_q   <= '0;
			hold_occ_q    <= '0;
		end else begin
			state_q <= state_d;
			if (fin_valid && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= fin_status;
				out_data_q   <= fin_data;
				out_occ_q    <= fin_occ;
			end else if (state_q == S_HOLD && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= hold_status_q;
				out_data_q   <= hold_data_q;
				out_occ_q    <= hold_occ_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_valid && !out_free) begin
				hold_status_q <= fin_status;
				hold_data_q   <= fin_data;
				hold_occ_q    <= fin_occ;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data_out  = out_data_q;
	assign occupancy = out_occ_q;

	// --- slot storage ------------------------------------------------------
	cqs_ram #(
		.WIDTH (cqs_pkg::DATA_W),
		.DEPTH (cqs_pkg::DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

@@ rtl/cqs_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module cqs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
